[hdl/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Parse phases, opcodes, frame kinds and status codes for the deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Parse phase of the current buffer
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAIL   = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  // Opcodes accepted in the first header byte
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Frame kinds reported on frame_type
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_PING  = 2'd2;
  localparam logic [1:0] KIND_PONG  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OPCODE   = 2'd1;
  localparam logic [1:0] ST_UNMASKED = 2'd2;
  localparam logic [1:0] ST_LENGTH   = 2'd3;

  // Seven-bit length codes that select an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Extended length byte counts and last mask key byte index
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_LAST   = 4'd3;

endpackage

[hdl/websocket_frame_deframer.sv]
// Latency: a result is valid in the cycle after its input transaction is accepted.
// Throughput: one byte per cycle unless a held result stalls on out_ready; the output
// register frees in the cycle it is taken, so in_ready stays high while results are consumed.
// Reset: synchronous rst returns to awaiting the first header byte, clears length,
// index and kind, and empties the output register; the mask key is not cleared.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one masked client frame per buffer, one byte per transaction, and
// delivers unmasked payload bytes, a status result, or both.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       has_data,
  output logic [1:0] frame_type,
  output logic [1:0] status,
  output logic       last
);
  import wsdf_pkg::*;

  // Parse state
  phase_t                 phase, phase_next;
  logic [3:0]             header_count, header_count_next;
  logic [LENGTH_BITS-1:0] frame_length, frame_length_next;
  logic [LENGTH_BITS-1:0] payload_index, payload_index_next;
  logic [1:0]             frame_kind, frame_kind_next;
  logic [7:0]             mask_key [4];

  // Result of the current byte
  logic       res_valid;
  logic [7:0] res_data;
  logic       res_has;
  logic [1:0] res_type;
  logic [1:0] res_status;
  logic       res_last;

  logic                   in_fire;
  logic [7:0]             unmasked;
  logic [LENGTH_BITS-1:0] len_shifted;
  logic [LENGTH_BITS-1:0] index_inc;
  logic [3:0]             count_inc;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Datapath helpers
  assign unmasked  = in_byte ^ mask_key[payload_index[1:0]];
  assign index_inc = payload_index + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign count_inc = header_count + 4'd1;
  assign len_shifted = (|frame_length[LENGTH_BITS-1 -: 8]) ? {LENGTH_BITS{1'b1}}
                       : {frame_length[LENGTH_BITS-9:0], in_byte};

  // Next state and result for one byte
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    frame_length_next  = frame_length;
    payload_index_next = payload_index;
    frame_kind_next    = frame_kind;
    res_valid  = 1'b0;
    res_data   = 8'd0;
    res_has    = 1'b0;
    res_type   = frame_kind;
    res_status = ST_OK;
    res_last   = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        res_type = KIND_TEXT;
        phase_next = PH_HDR1;
        unique case (in_byte[3:0])
          OP_TEXT:  frame_kind_next = KIND_TEXT;
          OP_CLOSE: frame_kind_next = KIND_CLOSE;
          OP_PING:  frame_kind_next = KIND_PING;
          OP_PONG:  frame_kind_next = KIND_PONG;
          default: begin
            frame_kind_next = KIND_TEXT;
            res_valid  = 1'b1;
            res_status = ST_OPCODE;
          end
        endcase
        if (!res_valid && buffer_end) begin
          res_valid  = 1'b1;
          res_status = ST_LENGTH;
          res_type   = frame_kind_next;
        end
        if (res_valid) begin
          res_last   = 1'b1;
          phase_next = buffer_end ? PH_HDR0 : PH_DROP;
        end
      end
      PH_HDR1: begin
        priority if (!in_byte[7]) begin
          res_valid  = 1'b1;
          res_status = ST_UNMASKED;
          res_last   = 1'b1;
          phase_next = buffer_end ? PH_HDR0 : PH_DROP;
        end else if (buffer_end) begin
          res_valid  = 1'b1;
          res_status = ST_LENGTH;
          res_last   = 1'b1;
          phase_next = PH_HDR0;
        end else if (in_byte[6:0] == LEN7_EXT16) begin
          frame_length_next = '0;
          header_count_next = EXT16_BYTES;
          phase_next        = PH_EXTLEN;
        end else if (in_byte[6:0] == LEN7_EXT64) begin
          frame_length_next = '0;
          header_count_next = EXT64_BYTES;
          phase_next        = PH_EXTLEN;
        end else begin
          frame_length_next = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
          header_count_next = 4'd0;
          phase_next        = PH_MASK;
        end
      end
      PH_EXTLEN: begin
        frame_length_next = len_shifted;
        header_count_next = header_count - 4'd1;
        if (buffer_end) begin
          res_valid  = 1'b1;
          res_status = ST_LENGTH;
          res_last   = 1'b1;
          phase_next = PH_HDR0;
        end else if (header_count_next == 4'd0) begin
          phase_next = PH_MASK;
        end
      end
      PH_MASK: begin
        header_count_next = count_inc;
        if (header_count != MASK_LAST) begin
          if (buffer_end) begin
            res_valid  = 1'b1;
            res_status = ST_LENGTH;
            res_last   = 1'b1;
            phase_next = PH_HDR0;
          end
        end else begin
          header_count_next  = 4'd0;
          payload_index_next = '0;
          priority if (frame_length == '0) begin
            // Empty payload: close the frame on the last mask byte
            res_valid  = 1'b1;
            res_last   = 1'b1;
            phase_next = buffer_end ? PH_HDR0 : PH_TRAIL;
          end else if (buffer_end) begin
            res_valid  = 1'b1;
            res_status = ST_LENGTH;
            res_last   = 1'b1;
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        priority if (index_inc == frame_length) begin
          res_data   = unmasked;
          res_has    = 1'b1;
          res_last   = 1'b1;
          phase_next = buffer_end ? PH_HDR0 : PH_TRAIL;
        end else if (buffer_end) begin
          res_status = ST_LENGTH;
          res_last   = 1'b1;
          phase_next = PH_HDR0;
        end else begin
          res_data           = unmasked;
          res_has            = 1'b1;
          payload_index_next = index_inc;
        end
      end
      PH_TRAIL: begin
        // Frame finished without buffer end: report the overrun once
        res_valid  = 1'b1;
        res_status = ST_LENGTH;
        res_last   = 1'b1;
        phase_next = buffer_end ? PH_HDR0 : PH_DROP;
      end
      default: begin
        // Drop bytes until the buffer ends
        if (buffer_end) phase_next = PH_HDR0;
      end
    endcase
  end

  // Advance parse state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      header_count  <= 4'd0;
      frame_length  <= '0;
      payload_index <= '0;
      frame_kind    <= KIND_TEXT;
    end else if (in_fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      frame_length  <= frame_length_next;
      payload_index <= payload_index_next;
      frame_kind    <= frame_kind_next;
    end
  end

  // Capture mask key bytes
  always_ff @(posedge clk) begin
    if (in_fire && phase == PH_MASK) begin
      mask_key[header_count[1:0]] <= in_byte;
    end
  end

  // Hold the result until the transaction downstream completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      data_byte  <= res_data;
      has_data   <= res_has;
      frame_type <= res_type;
      status     <= res_status;
      last       <= res_last;
    end
  end

endmodule
